@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// Each macro expands to one labeled concurrent assertion on a given clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Assertion that is checked during reset as well.
`define ASSERT_CLK_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ hdl/dtmf_pkg.sv @@
// Shared types, constants and constant tables for the DTMF tone generator.
// The quarter-wave sine table and the phase increments are built at elaboration.
// No dependencies.
package dtmf_pkg;

  localparam int SAMPLE_RATE_HZ   = 44100;
  localparam int BURST_SAMPLES    = 4096;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int AMP_W    = 14;
  localparam int PHASE_W  = 32;
  localparam int COUNT_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int KEY_W    = 4;
  localparam int MAG_W    = 15;

  localparam logic [AMP_W-1:0]   AMP_RESET  = AMP_W'(8000);
  localparam logic [COUNT_W-1:0] BURST_LAST = COUNT_W'(BURST_SAMPLES - 1);

  // Table index width, and the quarter wave that the table actually stores.
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int QDEPTH = SINE_TABLE_DEPTH / 4;
  localparam int QIDX_W = IDX_W - 2;
  localparam int QPOS_W = QIDX_W + 1;
  localparam logic [QPOS_W-1:0] QPOS_PEAK = QPOS_W'(QDEPTH);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic             start_req;
    logic [KEY_W-1:0] key;
  } dtmf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } dtmf_out_t;

  // Operands of one item handed from the phase stage to the synthesis stage.
  typedef struct packed {
    logic [PHASE_W-1:0] row_phase;
    logic [PHASE_W-1:0] column_phase;
    logic               active;
    logic               last;
  } dtmf_op_t;

  typedef logic [MAG_W-1:0]   qsine_table_t [QDEPTH];
  typedef logic [PHASE_W-1:0] inc_table_t [4];

  // Rounded phase increment for a tone of freq_hz.
  function automatic logic [PHASE_W-1:0] phase_inc(input int freq_hz);
    logic [63:0] num;
    logic [63:0] q;
    num = (64'(freq_hz) << 32) + 64'(SAMPLE_RATE_HZ / 2);
    q   = num / 64'(SAMPLE_RATE_HZ);
    return q[PHASE_W-1:0];
  endfunction

  // Magnitude of the sine at quarter-wave position j, in Q0.15, built from a
  // Taylor series in Q30 and rounded to nearest with the top saturated.
  function automatic logic [MAG_W-1:0] quarter_sine(input int j);
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    a    = (64'(j) * 64'd4 * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    a2   = (a * a) >> 30;
    term = a;
    sum  = $signed(a);
    term = ((term * a2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * a2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * a2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * a2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * a2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * a2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    term = ((term * a2) >> 30) / 64'd210;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    v = ($unsigned(sum) + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

  function automatic qsine_table_t build_qsine();
    qsine_table_t t;
    for (int j = 0; j < QDEPTH; j++) begin
      t[j] = quarter_sine(j);
    end
    return t;
  endfunction

  localparam qsine_table_t    QSINE_TABLE = build_qsine();
  localparam logic [MAG_W-1:0] QSINE_PEAK = quarter_sine(QDEPTH);

  // Low group selected by the key row, high group by the key column.
  localparam inc_table_t ROW_INC = '{phase_inc(697), phase_inc(770),
                                     phase_inc(852), phase_inc(941)};
  localparam inc_table_t COL_INC = '{phase_inc(1209), phase_inc(1336),
                                     phase_inc(1477), phase_inc(1633)};

endpackage

@@ hdl/dtmf_sine_scale.sv @@
// One sine component: quarter-wave table lookup scaled by the amplitude.
// Purely combinational. Depends on dtmf_pkg.
module dtmf_sine_scale (
  input  logic [dtmf_pkg::PHASE_W-1:0]         phase,
  input  logic [dtmf_pkg::AMP_W-1:0]           amplitude,
  output logic signed [dtmf_pkg::SAMPLE_W-1:0] scaled
);
  import dtmf_pkg::*;

  localparam int PROD_W = AMP_W + 1 + MAG_W + 1;

  logic [IDX_W-1:0]         idx;
  logic [1:0]               quad;
  logic [QPOS_W-1:0]        qpos;
  logic [MAG_W-1:0]         mag;
  logic signed [MAG_W:0]    sine;
  logic signed [PROD_W-1:0] product;

  always_comb begin
    idx  = phase[PHASE_W-1 -: IDX_W];
    quad = idx[IDX_W-1 -: 2];
    // Odd quadrants run the quarter wave backwards.
    if (quad[0]) begin
      qpos = QPOS_PEAK - {1'b0, idx[QIDX_W-1:0]};
    end else begin
      qpos = {1'b0, idx[QIDX_W-1:0]};
    end
    if (qpos == QPOS_PEAK) begin
      mag = QSINE_PEAK;
    end else begin
      mag = QSINE_TABLE[qpos[QIDX_W-1:0]];
    end
    if (quad[1]) begin
      sine = -$signed({1'b0, mag});
    end else begin
      sine = $signed({1'b0, mag});
    end
    // The arithmetic shift floors negative products as required.
    product = $signed({1'b0, amplitude}) * sine;
    scaled  = product[MAG_W +: SAMPLE_W];
  end

endmodule

@@ hdl/dtmf_phase_ctrl.sv @@
// Burst control and the two phase accumulators; registers each item's operands.
// Depends on dtmf_pkg.
module dtmf_phase_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dtmf_pkg::dtmf_in_t in_data,
  output logic               op_valid,
  input  logic               op_ready,
  output dtmf_pkg::dtmf_op_t op
);
  import dtmf_pkg::*;

  logic [PHASE_W-1:0] row_phase;
  logic [PHASE_W-1:0] column_phase;
  logic [KEY_W-1:0]   held_key;
  logic [COUNT_W-1:0] sample_count;
  logic               burst_active;

  logic               in_accept;
  logic               start;
  logic               active;
  logic [KEY_W-1:0]   key_sel;
  logic [COUNT_W-1:0] count_sel;
  dtmf_op_t           op_next;

  assign in_ready  = !op_valid || op_ready;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    start  = in_data.start_req;
    active = start || burst_active;
    if (start) begin
      key_sel              = in_data.key;
      count_sel            = '0;
      op_next.row_phase    = '0;
      op_next.column_phase = '0;
    end else begin
      key_sel              = held_key;
      count_sel            = sample_count;
      op_next.row_phase    = row_phase;
      op_next.column_phase = column_phase;
    end
    op_next.active = active;
    op_next.last   = active && (count_sel >= BURST_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_phase    <= '0;
      column_phase <= '0;
      held_key     <= '0;
      sample_count <= '0;
      burst_active <= 1'b0;
      op_valid     <= 1'b0;
    end else begin
      if (in_accept) begin
        op_valid <= 1'b1;
        if (active) begin
          row_phase    <= op_next.row_phase + ROW_INC[key_sel[KEY_W-1 -: 2]];
          column_phase <= op_next.column_phase + COL_INC[key_sel[1:0]];
          held_key     <= key_sel;
          sample_count <= count_sel + COUNT_W'(1);
          burst_active <= !op_next.last;
        end
      end else if (op_ready) begin
        op_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op <= op_next;
    end
  end

endmodule

@@ hdl/dtmf_tone_synth.sv @@
// Sums the row and column sine components and holds the result register.
// Depends on dtmf_pkg and dtmf_sine_scale.
module dtmf_tone_synth (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dtmf_pkg::AMP_W-1:0]  amplitude,
  input  logic                        op_valid,
  output logic                        op_ready,
  input  dtmf_pkg::dtmf_op_t          op,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dtmf_pkg::dtmf_out_t         out_data
);
  import dtmf_pkg::*;

  logic signed [SAMPLE_W-1:0] row_scaled;
  logic signed [SAMPLE_W-1:0] col_scaled;
  logic signed [SAMPLE_W-1:0] tone_sum;
  logic                       op_accept;

  dtmf_sine_scale u_row (
    .phase     (op.row_phase),
    .amplitude (amplitude),
    .scaled    (row_scaled)
  );

  dtmf_sine_scale u_col (
    .phase     (op.column_phase),
    .amplitude (amplitude),
    .scaled    (col_scaled)
  );

  // Each component stays within the amplitude, so the sum cannot overflow.
  assign tone_sum  = row_scaled + col_scaled;
  assign op_ready  = !out_valid || out_ready;
  assign op_accept = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_accept) begin
      out_data.sample <= op.active ? tone_sum : '0;
      out_data.last   <= op.last;
    end
  end

endmodule

@@ hdl/dtmf_dual_tone_generator.sv @@
// Top level of the DTMF dual-tone burst generator.
// Depends on dtmf_pkg, dtmf_phase_ctrl and dtmf_tone_synth.
//
// Usage:
//   Each item on the input channel (in_valid/in_ready/in_data) is one sample
//   tick. An item with start_req set latches key and starts a burst of
//   BURST_SAMPLES samples from zero phase; a start during a burst restarts it.
//   Every input item yields exactly one output item (out_valid/out_ready/
//   out_data): the sum of the row and column tones, or zero outside a burst,
//   with last set on the final sample of the burst.
//   The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the
//   amplitude of each sine component; it is always ready.
//   The item enters the phase register when it is accepted and the result
//   register after that, once the result register is free. One item is taken
//   every cycle while the receiver keeps out_ready high; the lookup, the two
//   multiplies and the add sit between those registers.
//   Reset clears the phases, the sample counter and both pipeline registers,
//   and sets the amplitude to 8000.
//   When the receiver stalls, the result is held; the phase register still
//   takes one more item if it is empty, then in_ready falls until out_ready returns.
module dtmf_dual_tone_generator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  dtmf_pkg::dtmf_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dtmf_pkg::dtmf_out_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dtmf_pkg::AMP_W-1:0] cfg_data
);
  import dtmf_pkg::*;

  logic [AMP_W-1:0] amplitude;
  logic             op_valid;
  logic             op_ready;
  dtmf_op_t         op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= AMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      amplitude <= cfg_data;
    end
  end

  dtmf_phase_ctrl u_phase_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  dtmf_tone_synth u_tone_synth (
    .clk       (clk),
    .rst       (rst),
    .amplitude (amplitude),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/dtmf_checker.sv @@
// Port-level checks for the DTMF tone generator, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module dtmf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // Reset empties the result register.
  `ASSERT_CLK_NORST(a_reset_empties, clk, rst |=> !out_valid)

  // A pending result is not withdrawn before it is taken.
  `ASSERT_CLK(a_out_holds, clk, rst, out_valid && !out_ready |=> out_valid)

  // A receiver that takes results never blocks the input.
  `ASSERT_CLK(a_ready_passes, clk, rst, out_ready |-> in_ready)

  // The result of an accepted item is checked to be valid once it has passed the phase and result registers.
  `ASSERT_CLK(a_latency, clk, rst, in_valid && in_ready |-> ##2 out_valid)

endmodule

bind dtmf_dual_tone_generator dtmf_checker u_checker (.*);
